// File: sv/dmc_pkg.sv
// dmc_pkg: shared opcodes, register indexes, command/status structs and helpers
// for the direct-mapped cache block. No dependencies.
package dmc_pkg;

  localparam int unsigned OpW      = 4;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned DataW    = 32;
  localparam int unsigned PenW     = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // access opcodes
  localparam logic [OpW-1:0] OP_LW    = 4'd0;
  localparam logic [OpW-1:0] OP_LHU   = 4'd1;
  localparam logic [OpW-1:0] OP_LH    = 4'd2;
  localparam logic [OpW-1:0] OP_LBU   = 4'd3;
  localparam logic [OpW-1:0] OP_LB    = 4'd4;
  localparam logic [OpW-1:0] OP_SW    = 4'd5;
  localparam logic [OpW-1:0] OP_SH    = 4'd6;
  localparam logic [OpW-1:0] OP_SB    = 4'd7;
  localparam logic [OpW-1:0] OP_FLUSH = 4'd8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_WT_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_READ_PEN  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_PEN = 2'd2;

  localparam logic [CfgDataW-1:0] PEN_RESET = 8'd10;
  localparam logic [CfgDataW-1:0] PEN_MIN   = 8'd2;

  // controller to datapath
  typedef struct packed {
    logic item_load;
    logic clr_step;
    logic item_rd;
    logic exec;
    logic fill_rd_line;
    logic fill_wb;
    logic fill_rd_mem;
    logic fill_wr_line;
    logic fin_rd;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic miss;
    logic fill_last;
    logic out_full;
  } sts_t;

  // penalty values below two count as two
  function automatic logic [PenW-1:0] eff_pen(input logic [CfgDataW-1:0] v);
    logic [CfgDataW-1:0] c;
    c = (v < PEN_MIN) ? PEN_MIN : v;
    return {1'b0, c};
  endfunction

endpackage

// File: sv/dmc_if.sv
// dmc_in_if / dmc_out_if: valid-ready channels for access beats and result beats.
// Depends on dmc_pkg for field widths.
interface dmc_in_if;
  logic                        valid;
  logic                        ready;
  logic [dmc_pkg::OpW-1:0]     op;
  logic [dmc_pkg::AddrW-1:0]   address;
  logic [dmc_pkg::DataW-1:0]   store_data;
  modport source (output valid, op, address, store_data, input ready);
  modport sink   (input valid, op, address, store_data, output ready);
endinterface

interface dmc_out_if;
  logic                        valid;
  logic                        ready;
  logic [dmc_pkg::DataW-1:0]   load_data;
  logic                        stall_res;
  modport source (output valid, load_data, stall_res, input ready);
  modport sink   (input valid, load_data, stall_res, output ready);
endinterface

// File: sv/direct_mapped_cache_with_miss_penalty.sv
// Direct-mapped cache with a miss penalty counter; one access beat at a time.
// A beat runs through the read, lookup, finish and output states; a miss adds a
// fill of FILL_WORDS words, each through line read, write-back, backing read and
// line write steps. Next beat accepted once the result is registered. After
// reset the backing memory is zeroed word by word (MEM_WORDS words, 4096 at
// defaults), during which no beat is accepted; config writes work.
module direct_mapped_cache_with_miss_penalty #(
  parameter int unsigned NUM_LINES  = 256,
  parameter int unsigned FILL_WORDS = 4,
  parameter int unsigned MEM_WORDS  = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  dmc_in_if.sink                       in_i,
  dmc_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [dmc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dmc_pkg::CfgDataW-1:0] cfg_data_i
);

  dmc_pkg::cmd_t cmd;
  dmc_pkg::sts_t sts;

  // sequencer
  dmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage and arithmetic
  dmc_datapath #(
    .NUM_LINES  (NUM_LINES),
    .FILL_WORDS (FILL_WORDS),
    .MEM_WORDS  (MEM_WORDS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (in_i.op),
    .address_i    (in_i.address),
    .store_data_i (in_i.store_data),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_data_o   (out_o.load_data),
    .out_stall_o  (out_o.stall_res)
  );

endmodule

// File: sv/dmc_ctrl.sv
// dmc_ctrl: sequencer for clear pass, lookup, line fill and result hand-off.
// Depends on dmc_pkg command/status structs.
module dmc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dmc_pkg::sts_t sts_i,
  output dmc_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_EXEC = 4'd3;
  localparam logic [3:0] S_FRL  = 4'd4;
  localparam logic [3:0] S_FWB  = 4'd5;
  localparam logic [3:0] S_FRM  = 4'd6;
  localparam logic [3:0] S_FWL  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.item_rd = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = sts_i.miss ? S_FRL : S_FIN;
      end
      S_FRL: begin
        cmd_o.fill_rd_line = 1'b1;
        state_d = S_FWB;
      end
      S_FWB: begin
        cmd_o.fill_wb = 1'b1;
        state_d = S_FRM;
      end
      S_FRM: begin
        cmd_o.fill_rd_mem = 1'b1;
        state_d = S_FWL;
      end
      S_FWL: begin
        cmd_o.fill_wr_line = 1'b1;
        state_d = sts_i.fill_last ? S_FIN : S_FRL;
      end
      S_FIN: begin
        cmd_o.fin_rd = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!sts_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/dmc_datapath.sv
// dmc_datapath: line tag/word memories, valid bits, backing memory, penalty
// counter, config registers and result register. Depends on dmc_pkg.
module dmc_datapath #(
  parameter int unsigned NUM_LINES  = 256,
  parameter int unsigned FILL_WORDS = 4,
  parameter int unsigned MEM_WORDS  = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dmc_pkg::cmd_t                   cmd_i,
  output dmc_pkg::sts_t                   sts_o,
  input  logic [dmc_pkg::OpW-1:0]         op_i,
  input  logic [dmc_pkg::AddrW-1:0]       address_i,
  input  logic [dmc_pkg::DataW-1:0]       store_data_i,
  input  logic                            cfg_we_i,
  input  logic [dmc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [dmc_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [dmc_pkg::DataW-1:0]       out_data_o,
  output logic                            out_stall_o
);

  localparam int unsigned LB   = $clog2(NUM_LINES);
  localparam int unsigned MB   = $clog2(MEM_WORDS);
  localparam int unsigned WW   = dmc_pkg::AddrW - 2;
  localparam int unsigned TagW = WW - LB;
  localparam int unsigned FCW  = $clog2(FILL_WORDS + 1);
  localparam int unsigned DW   = dmc_pkg::DataW;

  // item and config registers
  logic [dmc_pkg::OpW-1:0]      op_q;
  logic [dmc_pkg::AddrW-1:0]    addr_q;
  logic [DW-1:0]                sd_q;
  logic                         wt_q;
  logic [dmc_pkg::CfgDataW-1:0] rp_q, wp_q;

  // cache state
  logic [NUM_LINES-1:0]   valid_q;
  logic [dmc_pkg::PenW-1:0] pen_q;
  logic                   flag_q;
  logic [TagW-1:0]        tag_mem [NUM_LINES];
  logic [DW-1:0]          word_mem [NUM_LINES];
  logic [DW-1:0]          back_mem [MEM_WORDS];
  logic [TagW-1:0]        tag_rd_q;
  logic [DW-1:0]          word_rd_q, mem_rd_q;
  logic [MB-1:0]          clr_cnt_q;
  logic [FCW-1:0]         fill_cnt_q;
  logic                   stall_q;
  logic                   out_valid_q, out_stall_q;
  logic [DW-1:0]          out_data_q;

  // decode of the held item
  logic [LB-1:0]   idx;
  logic [TagW-1:0] tag;
  logic [1:0]      off;
  logic            is_load, is_store, is_flush, hit, pen_zero, one_line;
  assign idx      = addr_q[LB+1:2];
  assign tag      = addr_q[dmc_pkg::AddrW-1:LB+2];
  assign off      = addr_q[1:0];
  assign is_load  = (op_q <= dmc_pkg::OP_LB);
  assign is_store = (op_q >= dmc_pkg::OP_SW) && (op_q <= dmc_pkg::OP_SB);
  assign is_flush = (op_q == dmc_pkg::OP_FLUSH);
  assign hit      = valid_q[idx] && (tag_rd_q == tag);
  assign pen_zero = (pen_q == '0);
  assign one_line = is_store && wt_q && flag_q;

  // fill address for the current fill step
  logic [WW-1:0]   fw;
  logic [LB-1:0]   fli;
  logic [WW-1:0]   vw;
  assign fw  = addr_q[dmc_pkg::AddrW-1:2] + WW'(fill_cnt_q);
  assign fli = fw[LB-1:0];
  assign vw  = {tag_rd_q, fli};

  // sub-word merge into the old line word
  logic [DW-1:0] merged;
  always_comb begin
    merged = word_rd_q;
    unique case (op_q)
      dmc_pkg::OP_SW: merged = sd_q;
      dmc_pkg::OP_SH: begin
        if (off[1]) merged[31:16] = sd_q[15:0];
        else        merged[15:0]  = sd_q[15:0];
      end
      dmc_pkg::OP_SB: merged[8*off +: 8] = sd_q[7:0];
      default: merged = word_rd_q;
    endcase
  end

  // action decode for the lookup step
  logic exec_acc, wr_hit_wb, wr_hit_wt, miss;
  logic [dmc_pkg::PenW-1:0] miss_total;
  assign exec_acc  = cmd_i.exec && (is_load || is_store);
  assign miss      = (is_load || is_store) && pen_zero && !hit;
  assign wr_hit_wb = exec_acc && pen_zero && hit && is_store && !wt_q;
  assign wr_hit_wt = exec_acc && pen_zero && hit && is_store && wt_q && !flag_q;
  assign miss_total = dmc_pkg::eff_pen(rp_q) +
                      ((!wt_q && valid_q[idx]) ? dmc_pkg::eff_pen(wp_q) : '0);

  // line memories
  logic          lw_we;
  logic [LB-1:0] lw_wa, lr_a;
  logic [DW-1:0] lw_wd;
  assign lw_we = wr_hit_wb || wr_hit_wt || cmd_i.fill_wr_line;
  assign lw_wa = cmd_i.fill_wr_line ? fli : idx;
  assign lw_wd = cmd_i.fill_wr_line ? mem_rd_q : merged;
  assign lr_a  = cmd_i.fill_rd_line ? fli : idx;

  always_ff @(posedge clk_i) begin
    if (lw_we) word_mem[lw_wa] <= lw_wd;
    if (cmd_i.fill_wr_line) tag_mem[fli] <= fw[WW-1:LB];
    word_rd_q <= word_mem[lr_a];
    tag_rd_q  <= tag_mem[lr_a];
  end

  // backing memory
  logic          bm_we;
  logic [MB-1:0] bm_wa;
  logic [DW-1:0] bm_wd;
  always_comb begin
    bm_we = 1'b0;
    bm_wa = addr_q[MB+1:2];
    bm_wd = merged;
    priority if (cmd_i.clr_step) begin
      bm_we = 1'b1;
      bm_wa = clr_cnt_q;
      bm_wd = '0;
    end else if (cmd_i.fill_wb) begin
      bm_we = !wt_q && valid_q[fli];
      bm_wa = vw[MB-1:0];
      bm_wd = word_rd_q;
    end else if (wr_hit_wt) begin
      bm_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bm_we) back_mem[bm_wa] <= bm_wd;
    mem_rd_q <= back_mem[fw[MB-1:0]];
  end

  // item and config capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      op_q   <= op_i;
      addr_q <= address_i;
      sd_q   <= store_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt_q <= 1'b0;
      rp_q <= dmc_pkg::PEN_RESET;
      wp_q <= dmc_pkg::PEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dmc_pkg::CFG_WT_MODE:   wt_q <= cfg_data_i[0];
        dmc_pkg::CFG_READ_PEN:  rp_q <= cfg_data_i;
        dmc_pkg::CFG_WRITE_PEN: wp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits, penalty counter and write-through flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      pen_q   <= '0;
      flag_q  <= 1'b0;
      stall_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        stall_q <= (is_load || is_store) &&
                   (!pen_zero || !hit || (is_store && wt_q && !flag_q));
        if (is_flush) begin
          valid_q <= '0;
        end else if (exec_acc && !pen_zero) begin
          pen_q <= pen_q - 1'b1;
          if (pen_q == dmc_pkg::PenW'(1)) begin
            for (int i = 0; i < FILL_WORDS; i++) begin
              if (!one_line || i == 0) valid_q[idx + LB'(i)] <= 1'b1;
            end
          end
        end else if (exec_acc && hit && is_store && wt_q) begin
          if (flag_q) begin
            flag_q <= 1'b0;
          end else begin
            valid_q[idx] <= 1'b0;
            pen_q  <= dmc_pkg::eff_pen(wp_q) - 1'b1;
            flag_q <= 1'b1;
          end
        end else if (exec_acc && miss) begin
          pen_q <= miss_total - 1'b1;
        end
      end
      if (cmd_i.fill_wr_line) valid_q[fli] <= 1'b0;
    end
  end

  // clear pass and fill counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      fill_cnt_q <= '0;
    end else begin
      if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.exec) fill_cnt_q <= '0;
      else if (cmd_i.fill_wr_line) fill_cnt_q <= fill_cnt_q + 1'b1;
    end
  end

  // load formatting
  logic [DW-1:0] load_val;
  logic [15:0]   half;
  logic [7:0]    byte_v;
  assign half   = off[1] ? word_rd_q[31:16] : word_rd_q[15:0];
  assign byte_v = word_rd_q[8*off +: 8];
  always_comb begin
    unique case (op_q)
      dmc_pkg::OP_LW:  load_val = word_rd_q;
      dmc_pkg::OP_LHU: load_val = {16'h0, half};
      dmc_pkg::OP_LH:  load_val = {{16{half[15]}}, half};
      dmc_pkg::OP_LBU: load_val = {24'h0, byte_v};
      dmc_pkg::OP_LB:  load_val = {{24{byte_v[7]}}, byte_v};
      default:         load_val = '0;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q  <= load_val;
      out_stall_q <= stall_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_stall_o = out_stall_q;

  // status back to the sequencer
  assign sts_o.clr_last  = (clr_cnt_q == MB'(MEM_WORDS - 1));
  assign sts_o.miss      = miss;
  assign sts_o.fill_last = (fill_cnt_q == FCW'(FILL_WORDS - 1));
  assign sts_o.out_full  = out_valid_q && !out_ready_i;

endmodule

// File: sv/dmc_checker.sv
// dmc_checker: port-level checks on the cache top level, with its bind.
// Depends only on the top-level ports.
module dmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_data,
  input logic        out_stall
);

  // a stalled result beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_stall))
    else $error("result beat changed while stalled");

  // one access in flight: ready drops after an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while busy");

  // no result appears in the cycle right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early after accept");

endmodule

bind direct_mapped_cache_with_miss_penalty dmc_checker u_dmc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.load_data),
  .out_stall (out_o.stall_res)
);
